[rtl/fed_pkg.sv]
// ----------------------------------------------------------------------------
// fed_pkg: shared types and constants for the flag/escape deframer
// Byte codes, error codes, payload structs and count widths used by the
// deframer core, the output buffer, the top level and the checker.
// ----------------------------------------------------------------------------
package fed_pkg;

  // Largest number of decoded bytes counted in one frame.
  localparam int unsigned MAX_FRAME_BYTES = 1024;

  // Width of the internal saturating decoded byte counter.
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  // Width of the reported count field.
  localparam int unsigned OUT_CNT_W = 11;
  // Common width used to resize the counter to the reported field.
  localparam int unsigned CNTX_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  // Framing bytes.
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h02;
  localparam logic [7:0] ESC_ESC   = 8'h01;

  // Raw byte count, saturating, and the shortest legal buffer.
  localparam logic [2:0] RAW_SAT = 3'd7;
  localparam logic [2:0] MIN_RAW = 3'd5;

  // Item kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Error codes of the end-of-frame report.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_NO_START  = 3'd2;
  localparam logic [2:0] ERR_NO_END    = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 item_kind;
    logic                 frame_good;
    logic [OUT_CNT_W-1:0] decoded_count;
    logic [2:0]           error_code;
  } out_item_t;

  // Result of one input transaction as handed from the core to the buffer.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

[rtl/fed_core.sv]
// ----------------------------------------------------------------------------
// fed_core: per-byte deframing state and result logic
// Holds the frame state, unescapes each accepted raw byte, keeps the XOR check
// and byte counts, and forms the data item or end-of-frame report for it.
// ----------------------------------------------------------------------------
module fed_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  fed_pkg::in_item_t in_item,
  output fed_pkg::res_t     res
);

  logic                      start_ok_r, start_ok_nxt;
  logic                      esc_r, esc_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic [2:0]                raw_cnt_r, raw_cnt_nxt;
  logic [fed_pkg::CNT_W-1:0] dec_cnt_r, dec_cnt_nxt;
  logic                      bad_esc_r, bad_esc_nxt;
  logic                      ovf_r, ovf_nxt;

  logic [2:0]                 raw_bump;
  logic [fed_pkg::CNT_W-1:0]  dec_inc;
  logic [fed_pkg::CNTX_W-1:0] cnt_ext;
  logic [fed_pkg::CNTX_W-1:0] inc_ext;
  logic [7:0]                 dec_byte;
  logic                       dec_ok;
  logic [2:0]                 err;

  assign raw_bump = (raw_cnt_r < fed_pkg::RAW_SAT) ? raw_cnt_r + 3'd1 : raw_cnt_r;
  assign dec_inc  = dec_cnt_r + fed_pkg::CNT_W'(1);
  assign cnt_ext  = fed_pkg::CNTX_W'(dec_cnt_r);
  assign inc_ext  = fed_pkg::CNTX_W'(dec_inc);

  always_comb begin
    start_ok_nxt = start_ok_r;
    esc_nxt      = esc_r;
    xor_nxt      = xor_r;
    raw_cnt_nxt  = raw_cnt_r;
    dec_cnt_nxt  = dec_cnt_r;
    bad_esc_nxt  = bad_esc_r;
    ovf_nxt      = ovf_r;
    res          = '0;
    dec_byte     = in_item.raw_byte;
    dec_ok       = 1'b0;
    err          = fed_pkg::ERR_OK;

    if (raw_cnt_r < fed_pkg::MIN_RAW - 3'd1) begin
      err = fed_pkg::ERR_SHORT;
    end else if (!start_ok_r) begin
      err = fed_pkg::ERR_NO_START;
    end else if (in_item.raw_byte != fed_pkg::FLAG_BYTE) begin
      err = fed_pkg::ERR_NO_END;
    end else if (bad_esc_r) begin
      err = fed_pkg::ERR_BAD_ESC;
    end else if (ovf_r) begin
      err = fed_pkg::ERR_OVERFLOW;
    end else if (xor_r != 8'h00) begin
      err = fed_pkg::ERR_CHECKSUM;
    end

    if (fire) begin
      if (in_item.first_byte) begin
        // A first mark always restarts the buffer, dropping any old one.
        start_ok_nxt = (in_item.raw_byte == fed_pkg::FLAG_BYTE);
        esc_nxt      = 1'b0;
        xor_nxt      = 8'h00;
        raw_cnt_nxt  = 3'd1;
        dec_cnt_nxt  = '0;
        bad_esc_nxt  = 1'b0;
        ovf_nxt      = 1'b0;
        if (in_item.last_byte) begin
          res.valid            = 1'b1;
          res.item.item_kind   = fed_pkg::KIND_END;
          res.item.error_code  = fed_pkg::ERR_SHORT;
          raw_cnt_nxt          = '0;
          start_ok_nxt         = 1'b0;
        end
      end else if (in_item.last_byte) begin
        res.valid               = 1'b1;
        res.item.item_kind      = fed_pkg::KIND_END;
        res.item.error_code     = err;
        res.item.frame_good     = (err == fed_pkg::ERR_OK);
        res.item.decoded_count  = cnt_ext[fed_pkg::OUT_CNT_W-1:0];
        start_ok_nxt = 1'b0;
        esc_nxt      = 1'b0;
        xor_nxt      = 8'h00;
        raw_cnt_nxt  = '0;
        dec_cnt_nxt  = '0;
        bad_esc_nxt  = 1'b0;
        ovf_nxt      = 1'b0;
      end else begin
        raw_cnt_nxt = raw_bump;
        if (start_ok_r) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (in_item.raw_byte == fed_pkg::ESC_FLAG) begin
              dec_byte = fed_pkg::FLAG_BYTE;
              dec_ok   = 1'b1;
            end else if (in_item.raw_byte == fed_pkg::ESC_ESC) begin
              dec_byte = fed_pkg::ESC_BYTE;
              dec_ok   = 1'b1;
            end else begin
              bad_esc_nxt = 1'b1;
            end
          end else if (in_item.raw_byte == fed_pkg::ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            dec_ok = 1'b1;
          end

          if (dec_ok) begin
            // The check byte is folded in even once the frame has overflowed.
            xor_nxt = xor_r ^ dec_byte;
            if (dec_cnt_r >= fed_pkg::MAX_CNT) begin
              ovf_nxt = 1'b1;
            end else begin
              dec_cnt_nxt            = dec_inc;
              res.valid              = 1'b1;
              res.item.item_kind     = fed_pkg::KIND_DATA;
              res.item.data_byte     = dec_byte;
              res.item.decoded_count = inc_ext[fed_pkg::OUT_CNT_W-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_ok_r <= 1'b0;
      esc_r      <= 1'b0;
      xor_r      <= 8'h00;
      raw_cnt_r  <= '0;
      dec_cnt_r  <= '0;
      bad_esc_r  <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      start_ok_r <= start_ok_nxt;
      esc_r      <= esc_nxt;
      xor_r      <= xor_nxt;
      raw_cnt_r  <= raw_cnt_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      bad_esc_r  <= bad_esc_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

[rtl/fed_obuf.sv]
// ----------------------------------------------------------------------------
// fed_obuf: result register with skid stage
// Holds the result presented on the output channel and one more result that
// arrives while the receiver stalls, so the input side keeps moving.
// ----------------------------------------------------------------------------
module fed_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  fed_pkg::res_t      res,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output fed_pkg::out_item_t out_item
);

  logic                 out_v_r, out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  fed_pkg::out_item_t   out_d_r, out_d_nxt;
  fed_pkg::out_item_t   skid_d_r, skid_d_nxt;
  logic                 pop;

  assign pop       = out_v_r && out_ready;
  assign space_ok  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_item  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r) begin
      if (res.valid) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res.item;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        // No new result can arrive while the skid stage is full.
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else if (res.valid) begin
        out_d_nxt = res.item;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (res.valid) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

[rtl/flag_escape_deframer_xor_check.sv]
// ----------------------------------------------------------------------------
// flag_escape_deframer_xor_check: streaming deframer with XOR frame check
// Unescapes 0x7e-flagged frames one raw byte per transaction and reports each
// frame's status, decoded length and error code at its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one raw byte with first
//   and last marks. Output channel (out_valid/out_ready/out_item) carries
//   either a decoded data byte or an end-of-frame report. Opening flags,
//   escape bytes, bad escapes and bytes past the length limit give nothing.
//   A result is registered in the result register, or the skid stage when
//   the output stalls. Throughput: one raw byte per cycle while in_ready is
//   high, set by the single pass of decode logic from frame state to result register.
//   When the receiver stalls, one further result is held in a skid stage;
//   in_ready drops only while that stage is full, and rises again on the
//   cycle after the output is taken.
//   Reset (rst_n low, synchronous) clears the frame state and empties the
//   output side; bytes that come before a first mark are dropped until the
//   closing byte, which reports a short buffer or a missing start flag.
// ----------------------------------------------------------------------------
module flag_escape_deframer_xor_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fed_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fed_pkg::out_item_t out_item
);

  fed_pkg::res_t res;
  logic          fire;

  assign fire = in_valid && in_ready;

  fed_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_item (in_item),
    .res     (res)
  );

  fed_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[rtl/fed_checker.sv]
// ----------------------------------------------------------------------------
// fed_checker: port-level checks for the deframer
// Watches the top-level ports for result hold, reset behavior and the
// consistency of data items and end-of-frame reports.
// ----------------------------------------------------------------------------
module fed_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input fed_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input fed_pkg::out_item_t out_item
);

  // A stalled result stays put until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or vanished while stalled");

  // Reset leaves nothing on the output channel.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A report is good exactly when it carries no error.
  a_report_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.item_kind == fed_pkg::KIND_END |->
      out_item.frame_good == (out_item.error_code == fed_pkg::ERR_OK))
    else $error("report status disagrees with error code");

  // Data items carry no status and count at least the byte itself.
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.item_kind == fed_pkg::KIND_DATA |->
      !out_item.frame_good && out_item.error_code == fed_pkg::ERR_OK &&
      out_item.decoded_count != '0)
    else $error("data item with status or zero count");

  // An input byte marked both first and last, taken while the output is empty, reports a short frame.
  a_one_byte_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.first_byte && in_item.last_byte && !out_valid |=>
      out_valid && out_item.item_kind == fed_pkg::KIND_END &&
      out_item.error_code == fed_pkg::ERR_SHORT)
    else $error("one-byte buffer not reported as short");

endmodule

bind flag_escape_deframer_xor_check fed_checker u_fed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
